>>> hdl/d2s_pkg.sv
// ----------------------------------------------------------------------------
// Depth-to-space address generator package
// Request and response payload types, register indexes, error codes and the
// reciprocal table used to divide by the block size.
// ----------------------------------------------------------------------------
package d2s_pkg;

  localparam int unsigned IDX_W       = 38;
  localparam int unsigned RECIP_W     = 17;
  localparam int unsigned RECIP_SHIFT = 16;

  typedef enum logic [2:0] {
    CFG_BLK_SIDE    = 3'd0,
    CFG_LAYOUT_MODE = 3'd1,
    CFG_BATCH_COUNT = 3'd2,
    CFG_IN_DEPTH    = 3'd3,
    CFG_IN_HEIGHT   = 3'd4,
    CFG_IN_WIDTH    = 3'd5
  } cfg_reg_t;

  localparam logic [1:0] ERR_OK    = 2'd0;
  localparam logic [1:0] ERR_RANGE = 2'd1;
  localparam logic [1:0] ERR_DEPTH = 2'd2;

  typedef struct packed {
    logic [5:0]  batch_idx;
    logic [11:0] out_channel;
    logic [12:0] out_row;
    logic [12:0] out_col;
  } d2s_req_t;

  typedef struct packed {
    logic [IDX_W-1:0] source_index;
    logic [IDX_W-1:0] dest_index;
    logic [1:0]       error_code;
  } d2s_rsp_t;

  // Rounded-up value of 2^16 / b. A 13-bit value times this entry, shifted
  // down by 16, overestimates the quotient by at most one.
  function automatic logic [RECIP_W-1:0] recip_lookup(input logic [3:0] b);
    logic [RECIP_W-1:0] r;
    case (b)
      4'd1:    r = 17'd65536;
      4'd2:    r = 17'd32768;
      4'd3:    r = 17'd21846;
      4'd4:    r = 17'd16384;
      4'd5:    r = 17'd13108;
      4'd6:    r = 17'd10923;
      4'd7:    r = 17'd9363;
      4'd8:    r = 17'd8192;
      4'd9:    r = 17'd7282;
      4'd10:   r = 17'd6554;
      4'd11:   r = 17'd5958;
      4'd12:   r = 17'd5462;
      4'd13:   r = 17'd5042;
      4'd14:   r = 17'd4682;
      4'd15:   r = 17'd4370;
      default: r = 17'd0;
    endcase
    return r;
  endfunction

endpackage

>>> hdl/depth_to_space_address_gen.sv
// ----------------------------------------------------------------------------
// Depth-to-space address generator: source and destination index per request.
// One request per cycle is accepted while the output is not stalled and no
// derive pass runs. After reset and after every configuration write, a
// derive pass (a load step, then 13 divide steps) holds req_ready low.
// ----------------------------------------------------------------------------
module depth_to_space_address_gen (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  d2s_pkg::d2s_req_t req_data,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output d2s_pkg::d2s_rsp_t rsp_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [12:0]       cfg_data
);

  localparam int unsigned NSTAGE = 8;

  // --------------------------------------------------------------------------
  // Configuration registers. Writes are always taken; an unknown index is
  // ignored. Every write restarts the derive pass below.
  // --------------------------------------------------------------------------
  logic [3:0]  blk_side;
  logic        layout_mode;
  logic [6:0]  batch_count;
  logic [12:0] in_depth;
  logic [10:0] in_height;
  logic [10:0] in_width;
  logic        cfg_fire;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid & cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      blk_side    <= 4'd1;
      layout_mode <= 1'b0;
      batch_count <= 7'd1;
      in_depth    <= 13'd1;
      in_height   <= 11'd1;
      in_width    <= 11'd1;
    end else if (cfg_fire) begin
      unique case (cfg_index)
        d2s_pkg::CFG_BLK_SIDE:    blk_side    <= cfg_data[3:0];
        d2s_pkg::CFG_LAYOUT_MODE: layout_mode <= cfg_data[0];
        d2s_pkg::CFG_BATCH_COUNT: batch_count <= cfg_data[6:0];
        d2s_pkg::CFG_IN_DEPTH:    in_depth    <= cfg_data;
        d2s_pkg::CFG_IN_HEIGHT:   in_height   <= cfg_data[10:0];
        d2s_pkg::CFG_IN_WIDTH:    in_width    <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Derive pass. The output depth in_depth / (B*B) and the divisibility flag
  // depend only on configuration, so a restoring divider works them out one
  // quotient bit per cycle while requests are held off. The same pass
  // registers B*B, the output height and width, and the reciprocal of B.
  // --------------------------------------------------------------------------
  typedef enum logic [1:0] {PC_IDLE, PC_LOAD, PC_DIV} pc_state_t;

  pc_state_t                    pc_state;
  logic [7:0]                   sq;
  logic [14:0]                  out_height;
  logic [14:0]                  out_width;
  logic [d2s_pkg::RECIP_W-1:0]  recip;
  logic [12:0]                  div_q;      // dividend, shifted into quotient
  logic [7:0]                   div_rem;
  logic [3:0]                   div_cnt;
  logic                         div_err;
  logic [8:0]                   div_sh;
  logic                         div_ge;
  logic [7:0]                   div_rem_next;
  logic [12:0]                  div_q_next;
  logic                         busy;

  always_comb begin
    div_sh       = {div_rem, div_q[12]};
    div_ge       = div_sh >= {1'b0, sq};
    div_rem_next = div_ge ? 8'(div_sh - {1'b0, sq}) : div_sh[7:0];
    div_q_next   = {div_q[11:0], div_ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc_state <= PC_LOAD;
    end else if (cfg_fire) begin
      pc_state <= PC_LOAD;
    end else begin
      unique case (pc_state)
        PC_LOAD: begin
          sq         <= 8'(blk_side) * 8'(blk_side);
          out_height <= 15'(in_height) * 15'(blk_side);
          out_width  <= 15'(in_width) * 15'(blk_side);
          recip      <= d2s_pkg::recip_lookup(blk_side);
          div_q      <= in_depth;
          div_rem    <= 8'd0;
          div_cnt    <= 4'd0;
          pc_state   <= PC_DIV;
        end
        PC_DIV: begin
          div_q   <= div_q_next;
          div_rem <= div_rem_next;
          div_cnt <= div_cnt + 4'd1;
          if (div_cnt == 4'd12) begin
            // A zero block size divides nothing and is a depth error.
            div_err  <= (sq == 8'd0) || (div_rem_next != 8'd0);
            pc_state <= PC_IDLE;
          end
        end
        PC_IDLE: ;
        default: pc_state <= PC_LOAD;
      endcase
    end
  end

  assign busy = (pc_state != PC_IDLE);

  // Once the pass finishes, the quotient register is the output depth.
  logic [12:0] out_depth;
  assign out_depth = div_q;

  // --------------------------------------------------------------------------
  // Pipeline control. Each stage loads when it is empty or when the stage
  // after it moves, so bubbles close up and requests keep entering while a
  // finished response waits at the output register.
  // --------------------------------------------------------------------------
  logic [NSTAGE-1:0] v;
  logic [NSTAGE-1:0] en;
  logic              req_fire;

  always_comb begin
    en[NSTAGE-1] = !v[NSTAGE-1] || rsp_ready;
    for (int i = NSTAGE - 2; i >= 0; i--) begin
      en[i] = !v[i] || en[i+1];
    end
  end

  assign req_ready = en[0] && !busy;
  assign req_fire  = req_valid && req_ready;
  assign rsp_valid = v[NSTAGE-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) begin
        v[0] <= req_fire;
      end
      for (int i = 1; i < NSTAGE; i++) begin
        if (en[i]) begin
          v[i] <= v[i-1];
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 0: capture the request, check the ranges and multiply row and
  // column by the reciprocal of the block size.
  // --------------------------------------------------------------------------
  logic [5:0]  s0_bn;
  logic [11:0] s0_ch;
  logic [12:0] s0_row;
  logic [12:0] s0_col;
  logic [1:0]  s0_err;
  logic [29:0] s0_prow;
  logic [29:0] s0_pcol;
  logic        range_err;

  assign range_err = (7'(req_data.batch_idx) >= batch_count)
                  || (13'(req_data.out_channel) >= out_depth)
                  || (15'(req_data.out_row) >= out_height)
                  || (15'(req_data.out_col) >= out_width);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s0_bn   <= req_data.batch_idx;
      s0_ch   <= req_data.out_channel;
      s0_row  <= req_data.out_row;
      s0_col  <= req_data.out_col;
      // The divisibility check wins over the range check.
      s0_err  <= div_err   ? d2s_pkg::ERR_DEPTH :
                 range_err ? d2s_pkg::ERR_RANGE : d2s_pkg::ERR_OK;
      s0_prow <= 30'(req_data.out_row) * 30'(recip);
      s0_pcol <= 30'(req_data.out_col) * 30'(recip);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: estimated quotients and their products with the block size.
  // --------------------------------------------------------------------------
  logic [5:0]  s1_bn;
  logic [11:0] s1_ch;
  logic [12:0] s1_row;
  logic [12:0] s1_col;
  logic [1:0]  s1_err;
  logic [12:0] s1_qr;
  logic [12:0] s1_qc;
  logic [16:0] s1_qbr;
  logic [16:0] s1_qbc;
  logic [12:0] qr_est;
  logic [12:0] qc_est;

  assign qr_est = s0_prow[d2s_pkg::RECIP_SHIFT+12:d2s_pkg::RECIP_SHIFT];
  assign qc_est = s0_pcol[d2s_pkg::RECIP_SHIFT+12:d2s_pkg::RECIP_SHIFT];

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_bn  <= s0_bn;
      s1_ch  <= s0_ch;
      s1_row <= s0_row;
      s1_col <= s0_col;
      s1_err <= s0_err;
      s1_qr  <= qr_est;
      s1_qc  <= qc_est;
      s1_qbr <= 17'(qr_est) * 17'(blk_side);
      s1_qbc <= 17'(qc_est) * 17'(blk_side);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: correct an estimate that came out one too high and form the
  // in-block offsets of row and column.
  // --------------------------------------------------------------------------
  logic [5:0]  s2_bn;
  logic [11:0] s2_ch;
  logic [12:0] s2_row;
  logic [12:0] s2_col;
  logic [1:0]  s2_err;
  logic [12:0] s2_ir;
  logic [12:0] s2_ic;
  logic [3:0]  s2_rr;
  logic [3:0]  s2_rc;
  logic        row_over;
  logic        col_over;
  logic [16:0] row_rem;
  logic [16:0] col_rem;

  always_comb begin
    row_over = s1_qbr > 17'(s1_row);
    col_over = s1_qbc > 17'(s1_col);
    row_rem  = row_over ? 17'(s1_row) + 17'(blk_side) - s1_qbr : 17'(s1_row) - s1_qbr;
    col_rem  = col_over ? 17'(s1_col) + 17'(blk_side) - s1_qbc : 17'(s1_col) - s1_qbc;
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s2_bn  <= s1_bn;
      s2_ch  <= s1_ch;
      s2_row <= s1_row;
      s2_col <= s1_col;
      s2_err <= s1_err;
      s2_ir  <= row_over ? s1_qr - 13'd1 : s1_qr;
      s2_ic  <= col_over ? s1_qc - 13'd1 : s1_qc;
      s2_rr  <= row_rem[3:0];
      s2_rc  <= col_rem[3:0];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: channel group number inside the block.
  // --------------------------------------------------------------------------
  logic [5:0]  s3_bn;
  logic [11:0] s3_ch;
  logic [12:0] s3_row;
  logic [12:0] s3_col;
  logic [1:0]  s3_err;
  logic [12:0] s3_ir;
  logic [12:0] s3_ic;
  logic [7:0]  s3_grp;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s3_bn  <= s2_bn;
      s3_ch  <= s2_ch;
      s3_row <= s2_row;
      s3_col <= s2_col;
      s3_err <= s2_err;
      s3_ir  <= s2_ir;
      s3_ic  <= s2_ic;
      s3_grp <= 8'(s2_rr) * 8'(blk_side) + 8'(s2_rc);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: source channel. It only has to be right for in-range requests,
  // where it stays below in_depth.
  // --------------------------------------------------------------------------
  logic [5:0]  s4_bn;
  logic [11:0] s4_ch;
  logic [12:0] s4_row;
  logic [12:0] s4_col;
  logic [1:0]  s4_err;
  logic [12:0] s4_ir;
  logic [12:0] s4_ic;
  logic [12:0] s4_sd;
  logic [20:0] sd_sum;

  assign sd_sum = 21'(s3_ch) + 21'(s3_grp) * 21'(out_depth);

  always_ff @(posedge clk) begin
    if (en[4]) begin
      s4_bn  <= s3_bn;
      s4_ch  <= s3_ch;
      s4_row <= s3_row;
      s4_col <= s3_col;
      s4_err <= s3_err;
      s4_ir  <= s3_ir;
      s4_ic  <= s3_ic;
      s4_sd  <= sd_sum[12:0];
    end
  end

  // --------------------------------------------------------------------------
  // Stages 5 to 7: both linear indices are ((a0*m1 + a1)*m2 + a2)*m3 + a3.
  // The layout picks which coordinates and which dimensions fill the slots;
  // the user must hold the dimensions static while requests flow, as the block
  // does not enforce it. One multiply-add per stage; the last wraps modulo 2^38.
  // --------------------------------------------------------------------------
  logic [14:0] src_m1, src_m2, src_m3;
  logic [14:0] dst_m1, dst_m2, dst_m3;
  logic [12:0] src_a1, src_a2, src_a3;
  logic [12:0] dst_a1, dst_a2, dst_a3;

  always_comb begin
    if (layout_mode) begin
      src_m1 = 15'(in_height);
      src_m2 = 15'(in_width);
      src_m3 = 15'(in_depth);
      dst_m1 = out_height;
      dst_m2 = out_width;
      dst_m3 = 15'(out_depth);
      src_a1 = s4_ir;
      src_a2 = s4_ic;
      src_a3 = s4_sd;
      dst_a1 = s4_row;
      dst_a2 = s4_col;
      dst_a3 = 13'(s4_ch);
    end else begin
      src_m1 = 15'(in_depth);
      src_m2 = 15'(in_height);
      src_m3 = 15'(in_width);
      dst_m1 = 15'(out_depth);
      dst_m2 = out_height;
      dst_m3 = out_width;
      src_a1 = s4_sd;
      src_a2 = s4_ir;
      src_a3 = s4_ic;
      dst_a1 = 13'(s4_ch);
      dst_a2 = s4_row;
      dst_a3 = s4_col;
    end
  end

  logic [1:0]  s5_err;
  logic [21:0] s5_src;
  logic [21:0] s5_dst;
  logic [12:0] s5_src_a2, s5_src_a3;
  logic [12:0] s5_dst_a2, s5_dst_a3;

  always_ff @(posedge clk) begin
    if (en[5]) begin
      s5_err    <= s4_err;
      s5_src    <= 22'(s4_bn) * 22'(src_m1) + 22'(src_a1);
      s5_dst    <= 22'(s4_bn) * 22'(dst_m1) + 22'(dst_a1);
      s5_src_a2 <= src_a2;
      s5_src_a3 <= src_a3;
      s5_dst_a2 <= dst_a2;
      s5_dst_a3 <= dst_a3;
    end
  end

  logic [1:0]                 s6_err;
  logic [d2s_pkg::IDX_W-1:0]  s6_src;
  logic [d2s_pkg::IDX_W-1:0]  s6_dst;
  logic [12:0]                s6_src_a3;
  logic [12:0]                s6_dst_a3;

  always_ff @(posedge clk) begin
    if (en[6]) begin
      s6_err    <= s5_err;
      s6_src    <= 38'(s5_src) * 38'(src_m2) + 38'(s5_src_a2);
      s6_dst    <= 38'(s5_dst) * 38'(dst_m2) + 38'(s5_dst_a2);
      s6_src_a3 <= s5_src_a3;
      s6_dst_a3 <= s5_dst_a3;
    end
  end

  // Output register. A response with an error carries zero indices.
  logic [d2s_pkg::IDX_W-1:0] src_final;
  logic [d2s_pkg::IDX_W-1:0] dst_final;

  assign src_final = s6_src * 38'(src_m3) + 38'(s6_src_a3);
  assign dst_final = s6_dst * 38'(dst_m3) + 38'(s6_dst_a3);

  always_ff @(posedge clk) begin
    if (en[7]) begin
      rsp_data.error_code   <= s6_err;
      rsp_data.source_index <= (s6_err == d2s_pkg::ERR_OK) ? src_final : '0;
      rsp_data.dest_index   <= (s6_err == d2s_pkg::ERR_OK) ? dst_final : '0;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------

  // The derive pass ends with a quotient that rebuilds in_depth exactly
  // whenever it reports the depth as divisible.
  a_div_exact: assert property (@(posedge clk) disable iff (rst)
    (pc_state == PC_IDLE && $past(pc_state) == PC_DIV && !cfg_fire)
      |-> (div_err || (21'(out_depth) * 21'(sq) == 21'(in_depth))))
    else $error("derive pass left an inexact output depth");

  // After the quotient correction the in-block offsets lie below B.
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (v[2] && s2_err == d2s_pkg::ERR_OK)
      |-> ((s2_rr < blk_side) && (s2_rc < blk_side)))
    else $error("in-block offset not below block size");

  // A flagged response never carries an index.
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_data.error_code != d2s_pkg::ERR_OK)
      |-> ((rsp_data.source_index == '0) && (rsp_data.dest_index == '0)))
    else $error("error response with nonzero index");

endmodule
